FILE: rtl/msc_pkg.sv
// Shared types and constants for the mine neighborhood safe-cell counter.
package msc_pkg;

    localparam int MAX_SIDE_DEFAULT = 128;
    localparam int SIDE_W           = 8;
    localparam int SAFE_W           = 15;
    localparam int QUEUE_DEPTH      = 4;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd5;

    // Register index as seen on paddr[2].
    localparam logic REG_SIDE_LENGTH = 1'b0;

    typedef struct packed {
        logic mine;
        logic fin;
        logic prev;
        logic use_cur;
        logic use_p2;
        logic board_last;
    } t_op_flags;

    localparam int FLAGS_W = $bits(t_op_flags);

    typedef enum logic [2:0] {
        BK_RUN,
        BK_TAIL,
        BK_FLUSH,
        BK_DRAIN,
        BK_DONE
    } t_back_state;

endpackage

FILE: rtl/msc_front.sv
// Front end: accepts cells, tracks the board position and classifies each item.
module msc_front import msc_pkg::*; #(
    parameter int COL_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_has_mine,
    output logic              o_ready,
    input  logic [COL_W-1:0]  i_last,
    input  logic              i_restart,
    input  logic              i_q_full,
    output logic              o_push,
    output t_op_flags         o_flags,
    output logic [COL_W-1:0]  o_fin_col
);

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [COL_W-1:0] n_row;
    logic             col_nz;
    logic             row_nz;
    logic             col_end;
    logic             row_end;
    logic             accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    assign col_nz  = (r_col != '0);
    assign row_nz  = (r_row != '0);
    assign col_end = (r_col == i_last);
    assign row_end = (r_row == i_last);

    always_comb begin
        o_flags.mine       = i_has_mine;
        o_flags.fin        = col_nz || row_nz;
        o_flags.use_cur    = col_nz;
        o_flags.board_last = col_end && row_end;
        if (col_nz) begin
            o_flags.prev   = row_nz;
            o_flags.use_p2 = (r_col > COL_W'(1));
            o_fin_col      = r_col - COL_W'(1);
        end else begin
            o_flags.prev   = (r_row > COL_W'(1));
            o_flags.use_p2 = (i_last != '0);
            o_fin_col      = i_last;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + COL_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: rtl/msc_queue.sv
// Small first-in first-out queue between the front end and the back end.
module msc_queue import msc_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/msc_back.sv
// Back end: column store, neighborhood judging, final-row flush and result register.
module msc_back import msc_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT,
    parameter int COL_W    = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_op_flags         i_flags,
    input  logic [COL_W-1:0]  i_fin_col,
    output logic              o_pop,
    input  logic [COL_W-1:0]  i_last,
    input  logic              i_restart,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SAFE_W-1:0] o_safe_count
);

    // Each column entry holds the row-wise OR of the newest row and the OR of the two newest.
    logic [1:0]        r_mem [MAX_SIDE];
    logic [1:0]        r_rdata;
    logic              r_fwd;
    logic [1:0]        r_fwd_data;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [COL_W-1:0]  r_fcol;
    logic              r_p1;
    logic              r_p2;

    logic              r_b_valid;
    logic [COL_W-1:0]  r_b_addr;
    logic              r_b_h;
    logic              r_b_prev;
    logic              r_b_flush;

    logic [SAFE_W-1:0] r_total;
    logic              r_ovalid;
    logic [SAFE_W-1:0] r_out;

    logic              a_valid;
    logic [COL_W-1:0]  a_addr;
    logic              a_h;
    logic              a_prev;
    logic              a_flush;
    logic              emit;

    logic [1:0]        entry;
    logic              a_old;
    logic              b_old;
    logic              wr_en;
    logic [1:0]        wr_data;
    logic              safe_inc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (i_q_valid && i_flags.board_last) begin
                    n_state = BK_TAIL;
                end
            end
            BK_TAIL: begin
                n_state = BK_FLUSH;
            end
            BK_FLUSH: begin
                if (r_fcol == i_last) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        a_valid = 1'b0;
        a_addr  = i_fin_col;
        a_h     = 1'b0;
        a_prev  = 1'b0;
        a_flush = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            BK_RUN: begin
                o_pop   = i_q_valid;
                a_valid = i_q_valid && i_flags.fin;
                a_addr  = i_fin_col;
                a_h     = (i_flags.use_cur & i_flags.mine) | r_p1 | (i_flags.use_p2 & r_p2);
                a_prev  = i_flags.prev;
            end
            BK_TAIL: begin
                a_valid = 1'b1;
                a_addr  = i_last;
                a_h     = r_p1 | ((i_last != '0) & r_p2);
                a_prev  = (i_last != '0);
            end
            BK_FLUSH: begin
                a_valid = 1'b1;
                a_addr  = r_fcol;
                a_prev  = 1'b1;
                a_flush = 1'b1;
            end
            BK_DRAIN: begin
            end
            BK_DONE: begin
                emit = !r_ovalid || i_ready;
            end
            default: begin
            end
        endcase
    end

    assign entry    = r_fwd ? r_fwd_data : r_rdata;
    assign a_old    = r_b_prev & entry[1];
    assign b_old    = r_b_prev & entry[0];
    assign wr_en    = r_b_valid && !r_b_flush;
    assign wr_data  = {r_b_h, a_old | r_b_h};
    assign safe_inc = r_b_valid && r_b_prev && !(b_old || r_b_h);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_b_addr] <= wr_data;
        end
        if (a_valid) begin
            r_rdata <= r_mem[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
        r_b_addr   <= a_addr;
        r_b_h      <= a_h;
        r_b_prev   <= a_prev;
        r_b_flush  <= a_flush;
        r_out      <= emit ? r_total : r_out;
        if (o_pop) begin
            r_p2 <= r_p1;
            r_p1 <= i_flags.mine;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_RUN;
            r_fcol    <= '0;
            r_fwd     <= 1'b0;
            r_b_valid <= 1'b0;
            r_total   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fwd     <= a_valid && wr_en && (r_b_addr == a_addr);
            r_b_valid <= a_valid;
            if (r_state == BK_TAIL) begin
                r_fcol <= '0;
            end else if (r_state == BK_FLUSH) begin
                r_fcol <= r_fcol + COL_W'(1);
            end
            if (i_restart || emit) begin
                r_total <= '0;
            end else if (safe_inc) begin
                r_total <= r_total + SAFE_W'(1);
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_safe_count = r_out;

endmodule

FILE: rtl/mine_neighborhood_safe_count.sv
// Top level of the mine neighborhood safe-cell counter with its register port.
// Throughput: one cell per cycle while streaming a board. The flush after a board's last cell
// holds the back end, so up to four later cells queue and then input stalls. The flush walks
// each column of the effective side, where zero counts as one and above MAX_SIDE as MAX_SIDE;
// the count is then registered once the result register is free.
// Reset (synchronous, active low) sets side_length to 5 and empties the queue; writes restart.
module mine_neighborhood_safe_count import msc_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_has_mine,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SAFE_W-1:0]  o_safe_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int COL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic [SIDE_W-1:0] r_side;
    logic [COL_W-1:0]  last_idx;
    logic              cfg_wr;
    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    t_op_flags         push_flags;
    logic [COL_W-1:0]  push_col;
    logic [FLAGS_W+COL_W-1:0] head_data;
    t_op_flags         head_flags;
    logic [COL_W-1:0]  head_col;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIDE_LENGTH);
    assign prdata = (paddr[2] == REG_SIDE_LENGTH) ? {{(PDATA_W-SIDE_W){1'b0}}, r_side} : '0;

    assign head_flags = head_data[FLAGS_W+COL_W-1:COL_W];
    assign head_col   = head_data[COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
        end else if (cfg_wr) begin
            r_side <= pwdata[SIDE_W-1:0];
        end
    end

    always_comb begin
        if (r_side == '0) begin
            last_idx = '0;
        end else if (32'(r_side) > 32'(MAX_SIDE)) begin
            last_idx = COL_W'(MAX_SIDE - 1);
        end else begin
            last_idx = COL_W'(32'(r_side) - 32'd1);
        end
    end

    msc_front #(
        .COL_W (COL_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_has_mine (i_has_mine),
        .o_ready    (o_ready),
        .i_last     (last_idx),
        .i_restart  (cfg_wr),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_flags    (push_flags),
        .o_fin_col  (push_col)
    );

    msc_queue #(
        .DATA_W (FLAGS_W + COL_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_flags, push_col}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_data)
    );

    msc_back #(
        .MAX_SIDE (MAX_SIDE),
        .COL_W    (COL_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_flags      (head_flags),
        .i_fin_col    (head_col),
        .o_pop        (pop),
        .i_last       (last_idx),
        .i_restart    (cfg_wr),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_safe_count (o_safe_count)
    );

endmodule

FILE: rtl/msc_checker.sv
// Port-level checker for the safe-cell counter and its bind to the top level.
module msc_checker import msc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [SAFE_W-1:0]  o_safe_count,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_safe_count))
        else $error("Result changed or dropped while stalled.");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[2] == REG_SIDE_LENGTH) ##1
        (paddr[2] == REG_SIDE_LENGTH)
        |-> prdata[SIDE_W-1:0] == $past(pwdata[SIDE_W-1:0]))
        else $error("Side length readback does not match the written value.");

    a_prdata_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[PDATA_W-1:SIDE_W] == '0)
        else $error("Unused read data bits are not zero.");

endmodule

bind mine_neighborhood_safe_count msc_checker u_msc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_safe_count (o_safe_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

FILE: test/tb_top.sv
// Self-checking testbench for the mine neighborhood safe-cell counter.
`timescale 1ns / 1ps

module tb_top;
    import msc_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int MAX_CELLS    = MAX_SIDE_DEFAULT * MAX_SIDE_DEFAULT;
    localparam int RANDOM_CELLS = 1200;
    localparam logic [PADDR_W-1:0] SIDE_ADDR = {REG_SIDE_LENGTH, 2'b00};

    class safe_count_tracker;
        logic [SIDE_W-1:0] side_reg;
        bit                board [MAX_CELLS];
        int unsigned       fill;
        logic [SAFE_W-1:0] pending [$];
        int                errors;

        function new();
            side_reg = SIDE_RESET;
            fill = 0;
            errors = 0;
        endfunction

        function int unsigned side_used();
            if (side_reg == 0) return 1;
            if (side_reg > MAX_SIDE_DEFAULT) return MAX_SIDE_DEFAULT;
            return side_reg;
        endfunction

        function void apply_side(logic [SIDE_W-1:0] value);
            side_reg = value;
            fill = 0;
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void note_cell(logic mine);
            int unsigned n;
            int unsigned safe;
            int          rr;
            int          cc;
            bit          hit;
            n = side_used();
            board[fill] = mine;
            fill++;
            if (fill == n * n) begin
                safe = 0;
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        hit = 1'b0;
                        for (int dr = -1; dr <= 1; dr++) begin
                            for (int dc = -1; dc <= 1; dc++) begin
                                rr = r + dr;
                                cc = c + dc;
                                if (rr >= 0 && cc >= 0 && rr < n && cc < n) begin
                                    if (board[rr * n + cc]) hit = 1'b1;
                                end
                            end
                        end
                        if (!hit) safe++;
                    end
                end
                pending.push_back(SAFE_W'(safe));
                fill = 0;
            end
        endfunction

        function void check_count(logic [SAFE_W-1:0] got);
            logic [SAFE_W-1:0] want;
            if (pending.size() == 0) begin
                fail_note($sformatf("unexpected count: got %0d", got));
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    fail_note($sformatf("count mismatch: expected %0d, got %0d", want, got));
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_has_mine;
    logic               o_valid;
    logic               i_ready;
    logic [SAFE_W-1:0]  o_safe_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    safe_count_tracker tracker = new();
    bit                steady;
    int                hold_request;
    bit                holding;
    int                idle_cycles;
    int                random_cells;

    mine_neighborhood_safe_count dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_has_mine   (i_has_mine),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_safe_count (o_safe_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) tracker.note_cell(i_has_mine);
        if (i_rst_n && o_valid && i_ready) tracker.check_count(o_safe_count);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        int hold;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                holding = 1'b1;
                i_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
                holding = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    task automatic send_cell(input logic mine);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_has_mine <= mine;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_board(input int cells, input int pct);
        for (int k = 0; k < cells; k++) begin
            send_cell($urandom_range(0, 99) < pct);
            random_cells++;
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SIDE_ADDR;
        pwdata <= {24'($urandom_range(0, 32'hFFFFFF)), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.apply_side(value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_side();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= SIDE_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[SIDE_W-1:0] !== tracker.side_reg) begin
            tracker.fail_note($sformatf("side read mismatch: expected %0d, got %0d",
                                        tracker.side_reg, prdata[SIDE_W-1:0]));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_side(input logic [SIDE_W-1:0] value);
        write_side(value);
        check_side();
    endtask

    initial begin
        int n;
        int pct;
        int roll;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_has_mine = 1'b0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        hold_request = 0;
        holding = 1'b0;
        idle_cycles = 0;
        random_cells = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default side after reset, with mines on the top edge and in the far corner.
        check_side();
        for (int k = 0; k < 25; k++) send_cell(k == 2 || k == 24);
        wait_idle();

        // A zero side behaves as a single-cell board.
        set_side(8'd0);
        send_cell(1'b0);
        send_cell(1'b1);
        wait_idle();
        set_side(8'd1);
        send_cell(1'b1);
        send_cell(1'b0);
        wait_idle();
        set_side(8'd2);
        send_cell(1'b0);
        send_cell(1'b0);
        send_cell(1'b0);
        send_cell(1'b1);
        wait_idle();

        while (random_cells < RANDOM_CELLS) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) set_side(8'd0);
            else if (roll == 1) set_side(8'd1);
            else if (roll == 9) set_side(SIDE_W'($urandom_range(13, 24)));
            else set_side(SIDE_W'($urandom_range(2, 12)));
            n = tracker.side_used();
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                roll = $urandom_range(0, 9);
                if (roll == 0) pct = 0;
                else if (roll == 1) pct = 100;
                else if (roll < 5) pct = 5;
                else if (roll < 8) pct = 15;
                else pct = 35;
                if (random_cells + n * n <= RANDOM_CELLS) send_board(n * n, pct);
            end
            // Leave a board unfinished so that the next side write abandons it.
            if (n > 1 && random_cells + n * n <= RANDOM_CELLS && $urandom_range(0, 4) == 0) begin
                send_board($urandom_range(1, n * n - 1), 20);
            end
            wait_idle();
        end

        // An oversized side reads back as written; its partial board is abandoned.
        steady = 1'b0;
        set_side(8'd255);
        send_board(40, 10);
        wait_idle();

        // Hold the result side off long enough for single-cell boards to back up.
        set_side(8'd0);
        steady = 1'b1;
        hold_request = 300;
        while (!holding) @(negedge i_clk);
        send_board(60, 50);
        steady = 1'b0;
        wait_idle();

        if (tracker.pending.size() != 0) begin
            tracker.fail_note($sformatf("%0d counts never arrived", tracker.pending.size()));
        end
        if (tracker.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: mine_neighborhood_safe_count.f
rtl/msc_pkg.sv
rtl/msc_front.sv
rtl/msc_queue.sv
rtl/msc_back.sv
rtl/mine_neighborhood_safe_count.sv
rtl/msc_checker.sv
test/tb_top.sv
